// ===== rtl/dmac_pkg.sv =====
// shared types and constants for the direct-mapped address cache
// no dependencies
`default_nettype none

package dmac_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 64;
    localparam int WORD_W        = 64;
    localparam int KIND_W        = 2;
    localparam int INFO_W        = KIND_W + 2 * WORD_W;

    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_LOOKUP,
        CMD_DELETE,
        CMD_DELETE_RANGE
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  slot;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  range_end;
        logic [WORD_W-1:0] rec_a;
        logic [WORD_W-1:0] rec_b;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] found_a;
        logic [WORD_W-1:0] found_b;
    } res_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } req_stream_t;

endpackage

`default_nettype wire

// ===== rtl/dmac_front.sv =====
// front end: accepts requests, decodes them and buffers them for the engine
// depends on dmac_pkg
`default_nettype none

module dmac_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [1:0]                 command,
    input  wire logic [dmac_pkg::KIND_W-1:0] unwinder_kind,
    input  wire logic [dmac_pkg::KEY_W-1:0] key,
    input  wire logic [dmac_pkg::KEY_W-1:0] range_end,
    input  wire logic [dmac_pkg::WORD_W-1:0] record_a,
    input  wire logic [dmac_pkg::WORD_W-1:0] record_b,
    input  wire logic                       clearing,
    output dmac_pkg::req_stream_t           req_out,
    input  wire logic                       take
);
    import dmac_pkg::*;

    req_t               buf_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               accept;
    logic               pop_int;
    req_t               decoded;

    always_comb
    begin
        decoded.cmd       = cmd_t'(command);
        decoded.kind      = unwinder_kind;
        decoded.slot      = IDX_W'(key % KEY_W'(TABLE_ENTRIES));
        decoded.key       = key;
        decoded.range_end = range_end;
        decoded.rec_a     = record_a;
        decoded.rec_b     = record_b;
    end

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH)) || clearing;
    assign accept  = push && !full;
    assign pop_int = take && (count_reg != '0);

    assign req_out.valid = (count_reg != '0);
    assign req_out.req   = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_int ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !pop_int)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && pop_int)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmac_back.sv =====
// back end: table memories, clearing pass after reset and command execution
// depends on dmac_pkg
`default_nettype none

module dmac_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dmac_pkg::req_stream_t req_in,
    output logic                  take,
    output logic                  clearing,
    output logic                  res_push,
    output dmac_pkg::res_t        res,
    input  wire logic             res_full
);
    import dmac_pkg::*;

    logic [KEY_W-1:0]  key_mem  [TABLE_ENTRIES];
    logic [INFO_W-1:0] info_mem [TABLE_ENTRIES];

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  addr_next;
    req_t              op_reg;
    req_t              op_next;

    logic              key_we;
    logic [KEY_W-1:0]  key_wd;
    logic              info_we;
    logic [INFO_W-1:0] info_wd;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [INFO_W-1:0] rd_info_reg;

    logic [KIND_W-1:0] rd_kind;
    logic [WORD_W-1:0] rd_a;
    logic [WORD_W-1:0] rd_b;
    logic              key_match;
    logic              in_range;

    assign {rd_kind, rd_a, rd_b} = rd_info_reg;
    assign key_match = (rd_key_reg == op_reg.key);
    assign in_range  = (rd_key_reg >= op_reg.key) && (rd_key_reg < op_reg.range_end);
    assign clearing  = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        op_next    = op_reg;
        take       = 1'b0;
        key_we     = 1'b0;
        key_wd     = '0;
        info_we    = 1'b0;
        info_wd    = '0;
        wr_addr    = addr_reg;
        rd_en      = 1'b0;
        rd_addr    = addr_reg;
        res_push   = 1'b0;
        res        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                key_we  = 1'b1;
                info_we = 1'b1;
                if (addr_reg == LAST_SLOT)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_in.valid && !res_full)
                begin
                    take    = 1'b1;
                    op_next = req_in.req;
                    unique case (req_in.req.cmd) inside
                        CMD_INSERT:
                        begin
                            key_we   = 1'b1;
                            key_wd   = req_in.req.key;
                            info_we  = 1'b1;
                            info_wd  = {req_in.req.kind, req_in.req.rec_a, req_in.req.rec_b};
                            wr_addr  = req_in.req.slot;
                            res_push = 1'b1;
                        end
                        CMD_LOOKUP, CMD_DELETE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = req_in.req.slot;
                            addr_next  = req_in.req.slot;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            addr_next  = '0;
                            state_next = ST_SWEEP;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (op_reg.cmd == CMD_LOOKUP)
                begin
                    if (key_match && (rd_kind == op_reg.kind))
                    begin
                        res.hit     = 1'b1;
                        res.found_a = rd_a;
                        res.found_b = rd_b;
                    end
                end
                else if (key_match)
                begin
                    key_we = 1'b1;
                end
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                key_we = in_range;
                if (addr_reg == LAST_SLOT)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_wd;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
        end
    end

    // kind and payload store
    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_mem[wr_addr] <= info_wd;
        end
        if (rd_en)
        begin
            rd_info_reg <= info_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmac_result_q.sv =====
// result queue between the engine and the output ports
// depends on dmac_pkg
`default_nettype none

module dmac_result_q (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        res_push,
    input  wire dmac_pkg::res_t              res,
    output logic                             res_full,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             hit,
    output logic [dmac_pkg::WORD_W-1:0]      found_a,
    output logic [dmac_pkg::WORD_W-1:0]      found_b
);
    import dmac_pkg::*;

    res_t               buf_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               wr_en;
    logic               rd_en;

    assign res_full = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    assign hit     = buf_reg[rd_ptr_reg].hit;
    assign found_a = buf_reg[rd_ptr_reg].found_a;
    assign found_b = buf_reg[rd_ptr_reg].found_b;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_address_cache_core.sv =====
// direct-mapped address cache, 1024 entries, with single-key and range invalidate
// lookup and delete read the slot, then check it; range delete sweeps every slot
// throughput: one insert every cycle while the engine is idle and the result queue
// has room; no new request is taken until a lookup, delete or range delete is done
// after reset a clearing pass writes zero to every entry, with full high
// top level; depends on dmac_pkg, dmac_front, dmac_back, dmac_result_q
`default_nettype none

module direct_mapped_address_cache_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [1:0]                   command,
    input  wire logic [dmac_pkg::KIND_W-1:0]  unwinder_kind,
    input  wire logic [dmac_pkg::KEY_W-1:0]   key,
    input  wire logic [dmac_pkg::KEY_W-1:0]   range_end,
    input  wire logic [dmac_pkg::WORD_W-1:0]  record_a,
    input  wire logic [dmac_pkg::WORD_W-1:0]  record_b,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              hit,
    output logic [dmac_pkg::WORD_W-1:0]       found_a,
    output logic [dmac_pkg::WORD_W-1:0]       found_b
);
    import dmac_pkg::*;

    req_stream_t req_stream;
    logic        take;
    logic        clearing;
    logic        res_push;
    res_t        res;
    logic        res_full;

    dmac_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .unwinder_kind (unwinder_kind),
        .key           (key),
        .range_end     (range_end),
        .record_a      (record_a),
        .record_b      (record_b),
        .clearing      (clearing),
        .req_out       (req_stream),
        .take          (take)
    );

    dmac_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_in   (req_stream),
        .take     (take),
        .clearing (clearing),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full)
    );

    dmac_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .hit      (hit),
        .found_a  (found_a),
        .found_b  (found_b)
    );

endmodule

`default_nettype wire

// ===== rtl/dmac_checker.sv =====
// port-level checks for the direct-mapped address cache
// depends on dmac_pkg; bound to direct_mapped_address_cache_core
`default_nettype none

module dmac_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire logic                        full,
    input  wire logic                        empty,
    input  wire logic                        pop,
    input  wire logic                        hit,
    input  wire logic [dmac_pkg::WORD_W-1:0] found_a,
    input  wire logic [dmac_pkg::WORD_W-1:0] found_b
);
    import dmac_pkg::*;

    // a miss or a non-lookup request carries zero payload
    miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit) |-> (found_a == '0 && found_b == '0))
        else $error("miss result with nonzero payload");

    // the clearing pass holds off requests right after reset
    clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (full && empty))
        else $error("request port open during clearing pass");

    // a waiting result is not dropped
    result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");

    // a waiting result does not change
    result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(hit) && $stable(found_a) && $stable(found_b)))
        else $error("waiting result changed");

endmodule

bind direct_mapped_address_cache_core dmac_checker u_dmac_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .hit     (hit),
    .found_a (found_a),
    .found_b (found_b)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for direct_mapped_address_cache_core: directed and random requests through the
// push/full side, results popped with random stalls and checked against a shadow cache
// depends on dmac_pkg and the rtl of direct_mapped_address_cache_core
`default_nettype none

module tb_top;
    import dmac_pkg::*;

    localparam int RANDOM_REQS  = 650;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int HOLD_CYCLES  = 150;
    localparam int POOL_MAX     = 48;

    localparam logic [KEY_W-1:0] ALL_ONES = '1;
    localparam logic [KEY_W-1:0] K_SLOT0  = 64'h0000_0000_0000_1400;
    localparam logic [KEY_W-1:0] K_ALIAS0 = 64'h0000_0000_0000_0800;
    localparam logic [KEY_W-1:0] K_MID    = 64'h1234_5678_9abc_def0;
    localparam logic [KEY_W-1:0] K_FIVE   = 64'd5;
    localparam logic [KEY_W-1:0] K_ZERO   = '0;

    typedef struct {
        cmd_t              cmd;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  range_end;
        logic [WORD_W-1:0] rec_a;
        logic [WORD_W-1:0] rec_b;
    } cache_req_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                push          = 1'b0;
    logic                pop           = 1'b0;
    logic [1:0]          command       = '0;
    logic [KIND_W-1:0]   unwinder_kind = '0;
    logic [KEY_W-1:0]    key           = '0;
    logic [KEY_W-1:0]    range_end     = '0;
    logic [WORD_W-1:0]   record_a      = '0;
    logic [WORD_W-1:0]   record_b      = '0;
    logic                full;
    logic                empty;
    logic                hit;
    logic [WORD_W-1:0]   found_a;
    logic [WORD_W-1:0]   found_b;

    logic [KIND_W-1:0]   shadow_kind  [TABLE_ENTRIES];
    logic [KEY_W-1:0]    shadow_key   [TABLE_ENTRIES];
    logic [WORD_W-1:0]   shadow_rec_a [TABLE_ENTRIES];
    logic [WORD_W-1:0]   shadow_rec_b [TABLE_ENTRIES];

    cache_req_t          request_q[$];
    res_t                answer_q[$];
    logic [KEY_W-1:0]    live_keys[$];
    logic [KIND_W-1:0]   live_kinds[$];

    int                  accepted_cnt = 0;
    int                  total_reqs   = 0;
    int                  result_cnt   = 0;
    int                  mismatch_cnt = 0;
    int                  cycle_cnt    = 0;
    int                  hold_cnt     = 0;
    bit                  hold_done    = 1'b0;

    direct_mapped_address_cache_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .unwinder_kind (unwinder_kind),
        .key           (key),
        .range_end     (range_end),
        .record_a      (record_a),
        .record_b      (record_b),
        .empty         (empty),
        .pop           (pop),
        .hit           (hit),
        .found_a       (found_a),
        .found_b       (found_b)
    );

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_payload();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return ALL_ONES;
        return rand_word();
    endfunction

    // percentage of cycles a side rests, by phase of the run
    function automatic int idle_pct(bit sender);
        if (accepted_cnt < total_reqs / 3)
            return sender ? 37 : 63;
        if (accepted_cnt < 2 * total_reqs / 3)
            return sender ? 63 : 37;
        return 0;
    endfunction

    function automatic res_t shadow_cache_step(cache_req_t r);
        res_t        ans;
        int unsigned s;
        int          i;
        ans = '0;
        s   = int'(r.key % KEY_W'(TABLE_ENTRIES));
        case (r.cmd)
            CMD_INSERT:
            begin
                shadow_kind[s]  = r.kind;
                shadow_key[s]   = r.key;
                shadow_rec_a[s] = r.rec_a;
                shadow_rec_b[s] = r.rec_b;
            end
            CMD_LOOKUP:
            begin
                if (shadow_key[s] == r.key && shadow_kind[s] == r.kind)
                begin
                    ans.hit     = 1'b1;
                    ans.found_a = shadow_rec_a[s];
                    ans.found_b = shadow_rec_b[s];
                end
            end
            CMD_DELETE:
            begin
                if (shadow_key[s] == r.key)
                    shadow_key[s] = '0;
            end
            default:
            begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (shadow_key[i] >= r.key && shadow_key[i] < r.range_end)
                        shadow_key[i] = '0;
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %h want %h", result_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic add_req(cmd_t c, logic [KIND_W-1:0] kd, logic [KEY_W-1:0] k,
                           logic [KEY_W-1:0] e, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        cache_req_t r;
        r.cmd       = c;
        r.kind      = kd;
        r.key       = k;
        r.range_end = e;
        r.rec_a     = a;
        r.rec_b     = b;
        request_q.push_back(r);
        if (c == CMD_INSERT)
        begin
            live_keys.push_back(k);
            live_kinds.push_back(kd);
            if (live_keys.size() > POOL_MAX)
            begin
                void'(live_keys.pop_front());
                void'(live_kinds.pop_front());
            end
        end
    endtask

    task automatic add_random_req();
        int unsigned       pick;
        int unsigned       mode;
        int unsigned       j;
        cmd_t              c;
        logic [KEY_W-1:0]  base;
        logic [KEY_W-1:0]  k;
        logic [KEY_W-1:0]  e;
        logic [KIND_W-1:0] kd;
        pick = $urandom_range(99);
        mode = $urandom_range(9);
        j    = $urandom_range(live_keys.size() - 1);
        base = live_keys[j];
        kd   = KIND_W'($urandom());
        k    = rand_word();
        e    = rand_word();
        if (pick < 35)
        begin
            c = CMD_INSERT;
            // same slot as a live key, so it evicts it
            if (mode < 3)
                k = (rand_word() & ~64'h3ff) | (base & 64'h3ff);
            else if (mode < 5)
                k = KEY_W'($urandom_range(2047));
            else if (mode < 6)
                k = base;
        end
        else if (pick < 80)
        begin
            c = CMD_LOOKUP;
            if (mode < 6)
            begin
                k  = base;
                kd = live_kinds[j];
            end
            else if (mode < 7)
            begin
                k  = base;
                kd = live_kinds[j] ^ KIND_W'($urandom_range(1, 3));
            end
            else if (mode < 8)
                k = '0;
        end
        else if (pick < 96)
        begin
            c = CMD_DELETE;
            if (mode < 6)
                k = base;
            else if (mode < 7)
                k = '0;
            else if (mode < 8)
                k = (rand_word() & ~64'h3ff) | (base & 64'h3ff);
        end
        else
        begin
            c = CMD_DELETE_RANGE;
            if (mode < 4)
            begin
                k = (base < 64'd16) ? '0 : base - 64'($urandom_range(16));
                e = (base > ALL_ONES - 64'd16) ? ALL_ONES : base + 64'($urandom_range(1, 16));
            end
            else if (mode < 6)
            begin
                k = rand_word() | 64'h8000_0000_0000_0000;
                e = k - 64'($urandom_range(1000));
            end
            else if (mode < 8)
            begin
                k = '0;
                e = 64'($urandom_range(1, 4096));
            end
        end
        add_req(c, kd, k, e, rand_payload(), rand_payload());
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // request driver
    always @(posedge clk)
    begin
        cache_req_t head;
        bit         offer;
        if (rst_n)
        begin
            offer = 1'b0;
            if (push && full)
                offer = 1'b1;
            else
            begin
                if (push)
                begin
                    answer_q.push_back(shadow_cache_step(request_q.pop_front()));
                    accepted_cnt <= accepted_cnt + 1;
                end
                offer = (request_q.size() != 0) && ($urandom_range(99) >= idle_pct(1'b1));
            end
            if (offer)
            begin
                head          = request_q[0];
                push          <= 1'b1;
                command       <= head.cmd;
                unwinder_kind <= head.kind;
                key           <= head.key;
                range_end     <= head.range_end;
                record_a      <= head.rec_a;
                record_b      <= head.rec_b;
            end
            else
                push <= 1'b0;
        end
    end

    // long receiver hold-off so the block backs up and raises full
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt != 0)
                hold_cnt <= hold_cnt - 1;
            else if (!hold_done && accepted_cnt >= total_reqs * 5 / 6)
            begin
                hold_cnt  <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                result_cnt <= result_cnt + 1;
                if (answer_q.size() == 0)
                    report_mismatch("result with no request pending", 64'(hit), '0);
                else
                begin
                    want = answer_q.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", 64'(hit), 64'(want.hit));
                    if (found_a !== want.found_a)
                        report_mismatch("found_a", found_a, want.found_a);
                    if (found_b !== want.found_b)
                        report_mismatch("found_b", found_b, want.found_b);
                end
            end
            pop <= (hold_cnt == 0) && ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("direct_mapped_address_cache_core test failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            shadow_kind[i]  = '0;
            shadow_key[i]   = '0;
            shadow_rec_a[i] = '0;
            shadow_rec_b[i] = '0;
        end

        // cleared store: key zero with kind zero hits
        add_req(CMD_LOOKUP, 2'd0, K_ZERO, rand_word(), rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd1, K_ZERO, rand_word(), rand_word(), rand_word());
        add_req(CMD_INSERT, 2'd3, ALL_ONES, rand_word(), ALL_ONES, ALL_ONES);
        add_req(CMD_LOOKUP, 2'd3, ALL_ONES, rand_word(), rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd0, ALL_ONES, rand_word(), rand_word(), rand_word());
        add_req(CMD_INSERT, 2'd2, K_SLOT0, rand_word(),
                64'hdead_beef_0123_4567, 64'h0f0f_f0f0_a5a5_5a5a);
        // delete of a different key in the same slot leaves it alone
        add_req(CMD_DELETE, 2'd0, K_ALIAS0, rand_word(), rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd2, K_SLOT0, rand_word(), rand_word(), rand_word());
        add_req(CMD_DELETE, 2'd1, K_SLOT0, rand_word(), rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd2, K_SLOT0, rand_word(), rand_word(), rand_word());
        // deleted entry keeps kind and payloads under key zero
        add_req(CMD_LOOKUP, 2'd2, K_ZERO, rand_word(), rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd0, K_ZERO, rand_word(), rand_word(), rand_word());
        add_req(CMD_INSERT, 2'd1, K_MID, rand_word(), '0, '0);
        // empty ranges
        add_req(CMD_DELETE_RANGE, 2'd0, 64'h2000, 64'h1000, rand_word(), rand_word());
        add_req(CMD_DELETE_RANGE, 2'd3, K_MID, K_MID, rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd1, K_MID, rand_word(), rand_word(), rand_word());
        // widest range, end is exclusive so the all-ones key survives
        add_req(CMD_DELETE_RANGE, 2'd2, K_ZERO, ALL_ONES, rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd3, ALL_ONES, rand_word(), rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd1, K_MID, rand_word(), rand_word(), rand_word());
        add_req(CMD_INSERT, 2'd0, K_FIVE, rand_word(),
                64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        add_req(CMD_LOOKUP, 2'd0, K_FIVE, rand_word(), rand_word(), rand_word());
        add_req(CMD_DELETE, 2'd0, K_FIVE, rand_word(), rand_word(), rand_word());
        add_req(CMD_LOOKUP, 2'd0, K_FIVE, rand_word(), rand_word(), rand_word());

        for (i = 0; i < RANDOM_REQS; i++)
            add_random_req();
        total_reqs = request_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0)
            @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("direct_mapped_address_cache_core test passed");
        else
            $display("direct_mapped_address_cache_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/dmac_pkg.sv
rtl/dmac_front.sv
rtl/dmac_back.sv
rtl/dmac_result_q.sv
rtl/direct_mapped_address_cache_core.sv
rtl/dmac_checker.sv
verif/tb_top.sv
